// ----- rtl/rbpp_pkg.sv -----
package rbpp_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int NUM_AXES    = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HALF_X,
    REG_HALF_Y,
    REG_HALF_Z,
    REG_EDGE_RADIUS,
    REG_THREE_DIMS
  } reg_index_t;

endpackage

// ----- rtl/rbpp_point_if.sv -----
interface rbpp_point_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;
  logic signed [W-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

// ----- rtl/rbpp_proj_if.sv -----
interface rbpp_proj_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] proj_x;
  logic signed [W-1:0] proj_y;
  logic signed [W-1:0] proj_z;
  logic                on_flat_face;
  modport source (output valid, proj_x, proj_y, proj_z, on_flat_face, input ready);
  modport sink   (input valid, proj_x, proj_y, proj_z, on_flat_face, output ready);
endinterface

// ----- rtl/rounded_box_point_projection.sv -----
// Nearest surface point of an origin-centred box with rounded edges.
// Channels: point (sink) takes one Q-format point per transfer, proj (source)
// returns one projected point plus on_flat_face per transfer, in order.
// Configuration: cfg_we/cfg_index/cfg_data write half_x, half_y, half_z,
// edge_radius and three_dims; write only while the pipeline is empty.
// Pipeline: 2*COORD_WIDTH+6 register stages.
// Throughput: one point per cycle while proj does not stall.
// The depth is set by the bit-per-stage square root (COORD_WIDTH stages)
// and the bit-per-stage dividers (COORD_WIDTH stages, three lanes).
// Every stage has its own valid bit and loads when it is empty or the stage
// after it moves, so bubbles close up and point.ready stays high while any
// stage has room, even with a result waiting on proj.
// Reset: all valid bits clear, half lengths and edge radius go to 0 and
// three_dims to 1. A stall on proj holds every full stage; nothing is lost
// or repeated.
module rounded_box_point_projection #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  rbpp_point_if.sink                           point,
  rbpp_proj_if.source                          proj,
  input  logic                                 cfg_we,
  input  logic [rbpp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [COORD_WIDTH-2:0]               cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int SW = CW + 3;
  localparam int NS = 2 * CW + 6;
  localparam int SQ0 = 4;
  localparam int DV0 = 5 + CW;

  typedef struct packed {
    logic [2:0][CW-1:0] p;
    logic [2:0]         dneg;
    logic               flat;
  } side_t;

  typedef struct packed {
    side_t                sd;
    logic [2:0][2*CW-1:0] pr;
    logic [2*CW-1:0]      rad;
    logic [CW-1:0]        root;
    logic [SW-1:0]        rem;
  } sq_t;

  typedef struct packed {
    side_t              sd;
    logic [CW-1:0]      norm;
    logic [2:0][CW-1:0] rem;
    logic [2:0][CW-1:0] lq;
  } dv_t;

  // config
  logic [CW-2:0] half_x, half_y, half_z, edge_radius;
  logic          three_dims;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_x      <= '0;
      half_y      <= '0;
      half_z      <= '0;
      edge_radius <= '0;
      three_dims  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        rbpp_pkg::REG_HALF_X:      half_x      <= cfg_data;
        rbpp_pkg::REG_HALF_Y:      half_y      <= cfg_data;
        rbpp_pkg::REG_HALF_Z:      half_z      <= cfg_data;
        rbpp_pkg::REG_EDGE_RADIUS: edge_radius <= cfg_data;
        rbpp_pkg::REG_THREE_DIMS:  three_dims  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [2:0][CW-2:0] hv;
  assign hv = {half_z, half_y, half_x};

  // valid / enable chain
  logic [NS-1:0] v;
  logic [NS:0]   en;

  assign en[NS] = proj.ready;
  genvar gi;
  generate
    for (gi = 0; gi < NS; gi++) begin : g_en
      assign en[gi] = !v[gi] || en[gi+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= point.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign point.ready = en[0];

  // stage 1: magnitude, face gap, near test
  logic [2:0][CW-1:0] s1_w, s1_mag;
  logic [2:0][CW:0]   s1_gap;
  logic [2:0]         s1_near;
  logic [2:0][CW-1:0] w_in, mag_in;
  logic [2:0][CW:0]   gap_in;
  logic [2:0]         near_in;

  always_comb begin
    w_in = {point.point_z, point.point_y, point.point_x};
    for (int a = 0; a < 3; a++) begin
      mag_in[a]  = w_in[a][CW-1] ? (~w_in[a] + CW'(1)) : w_in[a];
      gap_in[a]  = {2'b00, hv[a]} - {1'b0, mag_in[a]};
      near_in[a] = $signed(gap_in[a]) < $signed({2'b00, edge_radius});
    end
    if (!three_dims) begin
      near_in[2] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_w    <= w_in;
      s1_mag  <= mag_in;
      s1_gap  <= gap_in;
      s1_near <= near_in;
    end
  end

  // stage 2: clamp to inner corner or replace nearest face
  side_t              s2_sd, sd2_in;
  logic [2:0][CW-1:0] s2_dm, dm_in;

  always_comb begin
    logic [CW-2:0] inner;
    logic [CW-1:0] ni;
    logic [1:0]    pick;
    sd2_in.flat = !(|s1_near);
    for (int a = 0; a < 3; a++) begin
      inner = (hv[a] > edge_radius) ? (hv[a] - edge_radius) : '0;
      ni    = {1'b0, inner};
      if (s1_near[a]) begin
        sd2_in.p[a]    = s1_w[a][CW-1] ? (~ni + CW'(1)) : ni;
        dm_in[a]       = (s1_mag[a] >= ni) ? (s1_mag[a] - ni) : (ni - s1_mag[a]);
        sd2_in.dneg[a] = s1_w[a][CW-1] ? (s1_mag[a] > ni) : (s1_mag[a] < ni);
      end else begin
        sd2_in.p[a]    = s1_w[a];
        dm_in[a]       = '0;
        sd2_in.dneg[a] = 1'b0;
      end
    end
    if (three_dims && ($signed(s1_gap[2]) < $signed(s1_gap[1]))) begin
      pick = ($signed(s1_gap[2]) < $signed(s1_gap[0])) ? 2'd2 : 2'd0;
    end else begin
      pick = ($signed(s1_gap[1]) < $signed(s1_gap[0])) ? 2'd1 : 2'd0;
    end
    if (sd2_in.flat) begin
      ni = {1'b0, hv[pick]};
      sd2_in.p[pick] = s1_w[pick][CW-1] ? (~ni + CW'(1)) : ni;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_sd <= sd2_in;
      s2_dm <= dm_in;
    end
  end

  // stage 3: squares and radius products
  side_t                s3_sd;
  logic [2:0][2*CW-1:0] s3_sq, s3_pr;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_sd <= s2_sd;
      for (int a = 0; a < 3; a++) begin
        s3_sq[a] <= s2_dm[a] * s2_dm[a];
        s3_pr[a] <= {1'b0, edge_radius} * s2_dm[a];
      end
    end
  end

  // stage 4: squared distance
  side_t                s4_sd;
  logic [2:0][2*CW-1:0] s4_pr;
  logic [2*CW-1:0]      s4_sum;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_sd  <= s3_sd;
      s4_pr  <= s3_pr;
      s4_sum <= s3_sq[0] + s3_sq[1] + s3_sq[2];
    end
  end

  // square root, one root bit per stage
  sq_t sqs [CW];

  generate
    for (gi = 0; gi < CW; gi++) begin : g_sqrt
      sq_t           src, nxt;
      logic [SW-1:0] r4, trial;
      logic          ge;
      if (gi == 0) begin : g_first
        always_comb begin
          src.sd   = s4_sd;
          src.pr   = s4_pr;
          src.rad  = s4_sum;
          src.root = '0;
          src.rem  = '0;
        end
      end else begin : g_next
        assign src = sqs[gi-1];
      end
      always_comb begin
        r4       = {src.rem[SW-3:0], src.rad[2*CW-1:2*CW-2]};
        trial    = {1'b0, src.root, 2'b01};
        ge       = r4 >= trial;
        nxt      = src;
        nxt.rem  = ge ? (r4 - trial) : r4;
        nxt.root = {src.root[CW-2:0], ge};
        nxt.rad  = {src.rad[2*CW-3:0], 2'b00};
      end
      always_ff @(posedge clk) begin
        if (en[SQ0+gi]) begin
          sqs[gi] <= nxt;
        end
      end
    end
  endgenerate

  // divider set-up: dividend = e*|d| + norm/2
  dv_t divs [CW+1];

  always_ff @(posedge clk) begin
    logic [2*CW-1:0] dd;
    if (en[DV0-1]) begin
      divs[0].sd   <= sqs[CW-1].sd;
      divs[0].norm <= sqs[CW-1].root;
      for (int a = 0; a < 3; a++) begin
        dd = sqs[CW-1].pr[a] + {{(CW+1){1'b0}}, sqs[CW-1].root[CW-1:1]};
        divs[0].rem[a] <= dd[2*CW-1:CW];
        divs[0].lq[a]  <= dd[CW-1:0];
      end
    end
  end

  // dividers, one quotient bit per stage on each lane
  generate
    for (gi = 0; gi < CW; gi++) begin : g_div
      dv_t nxt;
      always_comb begin
        logic [CW:0] t;
        logic        ge;
        nxt = divs[gi];
        for (int a = 0; a < 3; a++) begin
          t  = {divs[gi].rem[a], divs[gi].lq[a][CW-1]};
          ge = t >= {1'b0, divs[gi].norm};
          nxt.rem[a] = ge ? CW'(t - {1'b0, divs[gi].norm}) : t[CW-1:0];
          nxt.lq[a]  = {divs[gi].lq[a][CW-2:0], ge};
        end
      end
      always_ff @(posedge clk) begin
        if (en[DV0+gi]) begin
          divs[gi+1] <= nxt;
        end
      end
    end
  endgenerate

  // output: apply offset and saturate
  logic [2:0][CW-1:0] o_p, res;
  logic               o_flat;

  always_comb begin
    logic [CW+1:0] t;
    logic [CW+1:0] q;
    for (int a = 0; a < 3; a++) begin
      q = {2'b00, divs[CW].lq[a]};
      t = {{2{divs[CW].sd.p[a][CW-1]}}, divs[CW].sd.p[a]};
      if (!divs[CW].sd.flat && (divs[CW].norm != '0)) begin
        t = divs[CW].sd.dneg[a] ? (t - q) : (t + q);
      end
      if ((t[CW+1:CW-1] == 3'b000) || (t[CW+1:CW-1] == 3'b111)) begin
        res[a] = t[CW-1:0];
      end else if (t[CW+1]) begin
        res[a] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        res[a] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      o_p    <= res;
      o_flat <= divs[CW].sd.flat;
    end
  end

  assign proj.valid        = v[NS-1];
  assign proj.proj_x       = o_p[0];
  assign proj.proj_y       = o_p[1];
  assign proj.proj_z       = o_p[2];
  assign proj.on_flat_face = o_flat;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !proj.valid |-> point.ready)
    else $error("input stalled with an empty output stage");

  a_transfer_enters: assert property (@(posedge clk) disable iff (rst)
    (point.valid && point.ready) |=> v[0])
    else $error("transferred point missing from first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (v[SQ0] && !en[SQ0]) |=> v[SQ0])
    else $error("stalled square root stage dropped its item");

endmodule
